// File: design/cmw_pkg.sv
// ----------------------------------------------------------------------------
// cmw_pkg: shared types and constants for the command mailbox watchdog
// Field widths, register map, mode and severity codes, threshold helper.
// ----------------------------------------------------------------------------
`default_nettype none

package cmw_pkg;

  // Motors watched; the masks are 4 bits whatever the count.
  localparam int MotorCount = 4;
  localparam logic [3:0] MotorSpan =
    (MotorCount >= 4) ? 4'hF : 4'((1 << MotorCount) - 1);

  localparam int UsPerMs = 1000;

  // Configuration port
  localparam int CfgAw = 3;
  localparam logic CfgRegWarn  = 1'b0;
  localparam logic CfgRegFault = 1'b1;
  localparam logic [15:0] WarnLimitReset  = 16'd200;
  localparam logic [15:0] FaultLimitReset = 16'd500;

  // Threshold in us: a stall of more than limit ms holds exactly when
  // stall_us >= this.
  localparam int ThrW = 26;

  // Command kinds
  localparam logic [7:0] KindSpeed    = 8'd1;
  localparam logic [7:0] KindPosition = 8'd2;

  // Issue modes
  localparam logic [1:0] ModeCurrent  = 2'd0;
  localparam logic [1:0] ModeVelocity = 2'd1;
  localparam logic [1:0] ModePosition = 2'd2;

  // Severity
  localparam logic [1:0] SevOk    = 2'd0;
  localparam logic [1:0] SevWarn  = 2'd1;
  localparam logic [1:0] SevFault = 2'd2;

  // Reason
  localparam logic ReasonNone    = 1'b0;
  localparam logic ReasonTimeout = 1'b1;

  // Node state
  localparam logic [1:0] NodeInitial = 2'd0;
  localparam logic [1:0] NodeRunning = 2'd1;
  localparam logic [1:0] NodeFault   = 2'd2;

  typedef struct packed {
    logic [63:0] seq_first;
    logic [63:0] seq_second;
    logic [7:0]  target_motor;
    logic [7:0]  command_kind;
    logic signed [31:0] command_value;
    logic [47:0] time_us;
    logic [3:0]  online_mask;
  } cmw_item_t;

  typedef struct packed {
    logic        issue_valid;
    logic [7:0]  issue_node;
    logic [1:0]  issue_mode;
    logic signed [15:0] issue_target;
    logic [1:0]  severity_level;
    logic        reason_code;
    logic [1:0]  node_mode;
    logic [3:0]  disable_mask;
    logic [3:0]  zero_torque_mask;
  } cmw_result_t;

  typedef struct packed {
    logic [ThrW-1:0] warn_thr;
    logic [ThrW-1:0] fault_thr;
  } cmw_thr_t;

  // (limit + 1) * 1000, a 17 x 10 bit constant product
  function automatic logic [ThrW-1:0] thr_of(input logic [15:0] limit_ms);
    logic [16:0] lim_p1;
    lim_p1 = {1'b0, limit_ms} + 17'd1;
    return ThrW'(lim_p1) * ThrW'(UsPerMs);
  endfunction

endpackage

`default_nettype wire

// File: design/cmw_cfg.sv
// ----------------------------------------------------------------------------
// cmw_cfg: limit registers behind the APB port
// Holds both limits and the matching microsecond thresholds.
// ----------------------------------------------------------------------------
`default_nettype none

module cmw_cfg
  import cmw_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [CfgAw-1:0] paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready,
  output cmw_thr_t              thr_o
);

  logic [15:0] warn_lim_q, fault_lim_q;
  logic [ThrW-1:0] warn_thr_q, fault_thr_q;
  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warn_lim_q  <= WarnLimitReset;
      fault_lim_q <= FaultLimitReset;
      warn_thr_q  <= thr_of(WarnLimitReset);
      fault_thr_q <= thr_of(FaultLimitReset);
    end else if (wr_en) begin
      unique case (reg_sel)
        CfgRegWarn: begin
          warn_lim_q <= pwdata[15:0];
          warn_thr_q <= thr_of(pwdata[15:0]);
        end
        CfgRegFault: begin
          fault_lim_q <= pwdata[15:0];
          fault_thr_q <= thr_of(pwdata[15:0]);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      CfgRegWarn:  prdata = {16'd0, warn_lim_q};
      CfgRegFault: prdata = {16'd0, fault_lim_q};
      default:     prdata = 32'd0;
    endcase
  end

  assign thr_o.warn_thr  = warn_thr_q;
  assign thr_o.fault_thr = fault_thr_q;

endmodule

`default_nettype wire

// File: design/cmw_core.sv
// ----------------------------------------------------------------------------
// cmw_core: watchdog state and per-period decision logic
// Sequence check, command issue, stall timer and severity escalation.
// ----------------------------------------------------------------------------
`default_nettype none

module cmw_core
  import cmw_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire cmw_item_t   item_i,
  input  wire cmw_thr_t    thr_i,
  output cmw_result_t      res_o
);

  logic [63:0] last_q, last_d;
  logic        run_q, run_d;
  logic [47:0] start_q, start_d;
  logic [1:0]  sev_q, sev_d;
  logic        rsn_q, rsn_d;
  logic [1:0]  mode_q, mode_d;

  logic        issue;
  logic        match;
  logic        run_eff;
  logic [1:0]  sev1;
  logic        rsn1;
  logic [47:0] stall_us;
  logic [3:0]  online;

  always_comb begin
    issue   = (item_i.seq_first == item_i.seq_second) && (item_i.seq_first != last_q);
    last_d  = issue ? item_i.seq_first : last_q;
    mode_d  = (issue && last_q == 64'd0) ? NodeRunning : mode_q;
    match   = issue || (item_i.seq_first == last_q);
    run_eff = issue ? 1'b0 : run_q;
    online  = item_i.online_mask & MotorSpan;

    // An accepted command clears a timeout warning
    if (issue && sev_q == SevWarn && rsn_q == ReasonTimeout) begin
      sev1 = SevOk;
      rsn1 = ReasonNone;
    end else begin
      sev1 = sev_q;
      rsn1 = rsn_q;
    end

    start_d  = run_eff ? start_q : item_i.time_us;
    stall_us = item_i.time_us - start_d;
    run_d    = run_eff;
    sev_d    = sev1;
    rsn_d    = rsn1;

    res_o = '0;
    if (issue) begin
      res_o.issue_valid  = 1'b1;
      res_o.issue_node   = item_i.target_motor;
      res_o.issue_target = item_i.command_value[15:0];
      priority if (item_i.command_kind == KindSpeed)    res_o.issue_mode = ModeVelocity;
      else if (item_i.command_kind == KindPosition)     res_o.issue_mode = ModePosition;
      else                                              res_o.issue_mode = ModeCurrent;
    end

    start_d = run_eff ? start_q : (last_d != 64'd0 && match) ? item_i.time_us : start_q;

    if (last_d != 64'd0) begin
      if (match) begin
        run_d = 1'b1;
        priority if (stall_us >= {{(48-ThrW){1'b0}}, thr_i.fault_thr}) begin
          sev_d  = SevFault;
          rsn_d  = ReasonTimeout;
          mode_d = NodeFault;
          res_o.disable_mask = online;
        end else if (stall_us >= {{(48-ThrW){1'b0}}, thr_i.warn_thr}) begin
          if (sev1 == SevOk) begin
            sev_d = SevWarn;
            rsn_d = ReasonTimeout;
            res_o.zero_torque_mask = online;
          end
        end
      end else begin
        // Sequence moved with a write in progress: stop the timer
        run_d = 1'b0;
        if (sev1 == SevWarn && rsn1 == ReasonTimeout) begin
          sev_d = SevOk;
          rsn_d = ReasonNone;
        end
      end
    end

    res_o.severity_level = sev_d;
    res_o.reason_code    = rsn_d;
    res_o.node_mode      = mode_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= '0;
      run_q   <= 1'b0;
      start_q <= '0;
      sev_q   <= SevOk;
      rsn_q   <= ReasonNone;
      mode_q  <= NodeInitial;
    end else if (step_i) begin
      last_q  <= last_d;
      run_q   <= run_d;
      start_q <= start_d;
      sev_q   <= sev_d;
      rsn_q   <= rsn_d;
      mode_q  <= mode_d;
    end
  end

  a_fault_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sev_q == SevFault |=> sev_q == SevFault)
    else $error("fault severity cleared");

  a_issue_updates_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.issue_valid |=> last_q == $past(item_i.seq_first))
    else $error("issued command did not record its sequence");

  a_mask_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i |-> (res_o.disable_mask == 4'd0 || res_o.zero_torque_mask == 4'd0))
    else $error("disable and zero torque in one period");

endmodule

`default_nettype wire

// File: design/command_mailbox_watchdog.sv
// ----------------------------------------------------------------------------
// command_mailbox_watchdog: mailbox command issue with stall watchdog
//
// Each input transaction is one control period: the mailbox sequence pair,
// the command, the current time in microseconds and the online motor mask.
// Each one yields exactly one output transaction carrying the issued command
// (if any), the severity, reason and node state after the period, and the
// disable and zero torque masks for the online motors.
// Limits are set over the APB port (warn at 0x0, fault at 0x4, 16 bits each)
// and are converted to microsecond thresholds when written.
// The input register feeds the decision logic, and the result register loads
// from it when the transaction advances.
// Throughput: one transaction per cycle unless the receiver stalls; the
// watchdog state is updated in one pass of the compare and 48 bit subtract logic.
// Reset clears the sequence, timer and severity state, loads warn 200 ms and
// fault 500 ms, and empties both registers.
// When the receiver stalls, the result is held and the input register keeps
// its transaction; in_stall_o rises in the same cycle once that register is
// full, and an empty input register still takes one more transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module command_mailbox_watchdog
  import cmw_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,

  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [CfgAw-1:0] paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready,

  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [63:0]      seq_first_i,
  input  wire logic [63:0]      seq_second_i,
  input  wire logic [7:0]       target_motor_i,
  input  wire logic [7:0]       command_kind_i,
  input  wire logic signed [31:0] command_value_i,
  input  wire logic [47:0]      time_us_i,
  input  wire logic [3:0]       online_mask_i,

  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic                  issue_valid_o,
  output logic [7:0]            issue_node_o,
  output logic [1:0]            issue_mode_o,
  output logic signed [15:0]    issue_target_o,
  output logic [1:0]            severity_level_o,
  output logic                  reason_code_o,
  output logic [1:0]            node_mode_o,
  output logic [3:0]            disable_mask_o,
  output logic [3:0]            zero_torque_mask_o
);

  cmw_thr_t    thr;
  cmw_item_t   item_q;
  cmw_result_t res, res_q;
  logic        in_vld_q, in_vld_d;
  logic        out_vld_q, out_vld_d;
  logic        in_acc;
  logic        advance;

  cmw_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .thr_o   (thr)
  );

  cmw_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (item_q),
    .thr_i  (thr),
    .res_o  (res)
  );

  // Move the held transaction on whenever the result slot is free or draining
  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d  = in_acc ? 1'b1 : (advance ? 1'b0 : in_vld_q);
    out_vld_d = advance ? 1'b1 : (out_stall_i ? out_vld_q : 1'b0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q.seq_first     <= seq_first_i;
      item_q.seq_second    <= seq_second_i;
      item_q.target_motor  <= target_motor_i;
      item_q.command_kind  <= command_kind_i;
      item_q.command_value <= command_value_i;
      item_q.time_us       <= time_us_i;
      item_q.online_mask   <= online_mask_i;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign issue_valid_o      = res_q.issue_valid;
  assign issue_node_o       = res_q.issue_node;
  assign issue_mode_o       = res_q.issue_mode;
  assign issue_target_o     = res_q.issue_target;
  assign severity_level_o   = res_q.severity_level;
  assign reason_code_o      = res_q.reason_code;
  assign node_mode_o        = res_q.node_mode;
  assign disable_mask_o     = res_q.disable_mask;
  assign zero_torque_mask_o = res_q.zero_torque_mask;

  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_vld_q && out_stall_i)
    else $error("input stalled without a blocked result");

  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_vld_q)
    else $error("advanced transaction lost");

  a_held_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_stall_i |=> out_vld_q && res_q == $past(res_q))
    else $error("stalled result changed");

endmodule

`default_nettype wire
